/* hdl/lfu_pkg.sv */
// shared types and constants for the lfu cache table
package lfu_pkg;

    localparam int DATA_WIDTH          = 32;
    localparam int CAP_WIDTH           = 5;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;
    localparam int ENTRIES_DEFAULT     = 16;
    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int APB_ADDR_WIDTH      = 3;

    // word index on paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic ACTION_GET = 1'b0;
    localparam logic ACTION_PUT = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_MATCH,
        CELL_TOUCH,
        CELL_INSERT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     write_value;
        logic     evict;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_SWEEP,
        ST_INSERT,
        ST_DONE
    } t_state;

endpackage

/* hdl/lfu_cell.sv */
// one table entry plus its stage of the victim search chain
module lfu_cell import lfu_pkg::*; #(
    parameter int ENTRIES     = ENTRIES_DEFAULT,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
    parameter int CELL_INDEX  = 0,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctl              i_ctl,
    input  logic [DATA_WIDTH-1:0]  i_key,
    input  logic [DATA_WIDTH-1:0]  i_value,
    input  logic [IW-1:0]          i_ref_age,
    input  logic [IW-1:0]          i_slot_idx,
    input  logic [IW-1:0]          i_victim_idx,
    output logic                   o_match,
    output logic [DATA_WIDTH-1:0]  o_value,
    output logic [IW-1:0]          o_age,
    // search record from the previous cell
    input  logic                   i_best_valid,
    input  logic [COUNT_WIDTH-1:0] i_best_count,
    input  logic [IW-1:0]          i_best_age,
    input  logic [IW-1:0]          i_best_idx,
    input  logic [DATA_WIDTH-1:0]  i_best_key,
    input  logic                   i_free_found,
    input  logic [IW-1:0]          i_free_idx,
    // search record toward the next cell
    output logic                   o_best_valid,
    output logic [COUNT_WIDTH-1:0] o_best_count,
    output logic [IW-1:0]          o_best_age,
    output logic [IW-1:0]          o_best_idx,
    output logic [DATA_WIDTH-1:0]  o_best_key,
    output logic                   o_free_found,
    output logic [IW-1:0]          o_free_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_INDEX);

    logic                   r_valid, n_valid;
    logic                   r_match, n_match;
    logic [DATA_WIDTH-1:0]  r_key, n_key;
    logic [DATA_WIDTH-1:0]  r_value, n_value;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [IW-1:0]          r_age, n_age;

    logic                   r_best_valid, n_best_valid;
    logic [COUNT_WIDTH-1:0] r_best_count, n_best_count;
    logic [IW-1:0]          r_best_age, n_best_age;
    logic [IW-1:0]          r_best_idx, n_best_idx;
    logic [DATA_WIDTH-1:0]  r_best_key, n_best_key;
    logic                   r_free_found, n_free_found;
    logic [IW-1:0]          r_free_idx, n_free_idx;

    logic is_slot, is_victim, take;
    logic [COUNT_WIDTH-1:0] count_inc;

    assign count_inc = (r_count == '1) ? r_count : r_count + 1'b1;
    assign is_slot   = (i_slot_idx == MY_IDX);
    assign is_victim = i_ctl.evict && (i_victim_idx == MY_IDX);

    always_comb begin
        n_valid = r_valid;
        n_match = r_match;
        n_key   = r_key;
        n_value = r_value;
        n_count = r_count;
        n_age   = r_age;
        case (i_ctl.op)
            CELL_MATCH: begin
                n_match = r_valid && (r_key == i_key);
            end
            CELL_TOUCH: begin
                if (r_match) begin
                    n_count = count_inc;
                    n_age   = '0;
                    if (i_ctl.write_value) begin
                        n_value = i_value;
                    end
                end else if (r_valid && (r_age < i_ref_age)) begin
                    n_age = r_age + 1'b1;
                end
            end
            CELL_INSERT: begin
                if (is_slot) begin
                    n_valid = 1'b1;
                    n_key   = i_key;
                    n_value = i_value;
                    n_count = COUNT_WIDTH'(1);
                    n_age   = '0;
                end else if (is_victim) begin
                    n_valid = 1'b0;
                end else if (r_valid && !(i_ctl.evict && (r_age > i_ref_age))) begin
                    n_age = r_age + 1'b1;
                end
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    // lowest count, then oldest, then lowest index
    assign take = r_valid && (!i_best_valid || (r_count < i_best_count) ||
                  ((r_count == i_best_count) && (r_age > i_best_age)));

    always_comb begin
        n_best_valid = i_best_valid;
        n_best_count = i_best_count;
        n_best_age   = i_best_age;
        n_best_idx   = i_best_idx;
        n_best_key   = i_best_key;
        n_free_found = i_free_found;
        n_free_idx   = i_free_idx;
        if (take) begin
            n_best_valid = 1'b1;
            n_best_count = r_count;
            n_best_age   = r_age;
            n_best_idx   = MY_IDX;
            n_best_key   = r_key;
        end
        if (!i_free_found && !r_valid) begin
            n_free_found = 1'b1;
            n_free_idx   = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_match      <= n_match;
        r_key        <= n_key;
        r_value      <= n_value;
        r_count      <= n_count;
        r_age        <= n_age;
        r_best_valid <= n_best_valid;
        r_best_count <= n_best_count;
        r_best_age   <= n_best_age;
        r_best_idx   <= n_best_idx;
        r_best_key   <= n_best_key;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
    end

    assign o_match      = r_match;
    assign o_value      = r_value;
    assign o_age        = r_age;
    assign o_best_valid = r_best_valid;
    assign o_best_count = r_best_count;
    assign o_best_age   = r_best_age;
    assign o_best_idx   = r_best_idx;
    assign o_best_key   = r_best_key;
    assign o_free_found = r_free_found;
    assign o_free_idx   = r_free_idx;

endmodule

/* hdl/lfu_cache_table.sv */
// lfu key-value table with lru tie break, top level
//
// Input stream (s_axis): tuser carries the action (get or put), tdata the key
// and the value. Output stream (m_axis): one transaction per input transaction,
// tuser carries hit and evicted, tdata the read value and the evicted key. The
// user writes the capacity register over the apb port only while idle; unchecked.
//
// One access at a time. A get, a put that hits, or any access with capacity
// zero runs from accept to the result in the output register through lookup,
// decide and hand-off. A put of a new key also runs the victim search down the
// row of cells, one cell per cycle, and then an insert step before the hand-off.
// The next transaction is accepted the cycle after the result moves into the
// output register.
//
// Reset clears all entry valid bits, occupancy and the output valid, and sets
// capacity to 16. A stalled receiver holds the result in the output register;
// the next access runs meanwhile and waits in the hand-off step until the
// output register frees up.
module lfu_cache_table import lfu_pkg::*; #(
    parameter int ENTRIES     = ENTRIES_DEFAULT,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [2*DATA_WIDTH-1:0]   s_axis_tdata,  // key, value
    input  logic [0:0]                s_axis_tuser,  // action
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [2*DATA_WIDTH-1:0]   m_axis_tdata,  // read_value, evicted_key
    output logic [1:0]                m_axis_tuser,  // hit, evicted
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (OW > CAP_WIDTH) ? OW : CAP_WIDTH;

    t_state r_state, n_state;

    logic [CAP_WIDTH-1:0]  r_capacity;
    logic [OW-1:0]         r_occ, n_occ;
    logic [IW-1:0]         r_sweep, n_sweep;
    logic                  r_action;
    logic [DATA_WIDTH-1:0] r_key, r_value;

    logic                  r_res_hit, n_res_hit;
    logic [DATA_WIDTH-1:0] r_res_rd, n_res_rd;
    logic                  r_res_ev, n_res_ev;
    logic [DATA_WIDTH-1:0] r_res_evk, n_res_evk;

    logic                  r_m_valid;
    logic                  r_m_hit, r_m_ev;
    logic [DATA_WIDTH-1:0] r_m_rd, r_m_evk;

    t_cell_ctl     cell_ctl;
    logic [IW-1:0] ref_age, slot_idx;

    logic                  cell_match [ENTRIES];
    logic [DATA_WIDTH-1:0] cell_value [ENTRIES];
    logic [IW-1:0]         cell_age   [ENTRIES];

    logic                   ch_valid [ENTRIES+1];
    logic [COUNT_WIDTH-1:0] ch_count [ENTRIES+1];
    logic [IW-1:0]          ch_age   [ENTRIES+1];
    logic [IW-1:0]          ch_idx   [ENTRIES+1];
    logic [DATA_WIDTH-1:0]  ch_key   [ENTRIES+1];
    logic                   ch_free  [ENTRIES+1];
    logic [IW-1:0]          ch_fidx  [ENTRIES+1];

    logic                  any_hit;
    logic [DATA_WIDTH-1:0] hit_value;
    logic [IW-1:0]         hit_age;
    logic [CMPW-1:0]       cap_ext, cap_eff;
    logic                  cap_zero, occ_full, evict, slot_en, can_load, cfg_wr;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(r_capacity) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[CAP_WIDTH-1:0];
        end
    end

    assign cap_ext  = CMPW'(r_capacity);
    assign cap_eff  = (cap_ext > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_ext;
    assign cap_zero = (cap_eff == '0);
    assign occ_full = (CMPW'(r_occ) >= cap_eff);

    // ---------------- row of cells ----------------
    assign ch_valid[0] = 1'b0;
    assign ch_count[0] = '0;
    assign ch_age[0]   = '0;
    assign ch_idx[0]   = '0;
    assign ch_key[0]   = '0;
    assign ch_free[0]  = 1'b0;
    assign ch_fidx[0]  = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_cell #(
            .ENTRIES     (ENTRIES),
            .COUNT_WIDTH (COUNT_WIDTH),
            .CELL_INDEX  (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_key        (r_key),
            .i_value      (r_value),
            .i_ref_age    (ref_age),
            .i_slot_idx   (slot_idx),
            .i_victim_idx (ch_idx[ENTRIES]),
            .o_match      (cell_match[g]),
            .o_value      (cell_value[g]),
            .o_age        (cell_age[g]),
            .i_best_valid (ch_valid[g]),
            .i_best_count (ch_count[g]),
            .i_best_age   (ch_age[g]),
            .i_best_idx   (ch_idx[g]),
            .i_best_key   (ch_key[g]),
            .i_free_found (ch_free[g]),
            .i_free_idx   (ch_fidx[g]),
            .o_best_valid (ch_valid[g+1]),
            .o_best_count (ch_count[g+1]),
            .o_best_age   (ch_age[g+1]),
            .o_best_idx   (ch_idx[g+1]),
            .o_best_key   (ch_key[g+1]),
            .o_free_found (ch_free[g+1]),
            .o_free_idx   (ch_fidx[g+1])
        );
    end

    // at most one cell matches, so the selects are plain or-reductions
    always_comb begin
        any_hit   = 1'b0;
        hit_value = '0;
        hit_age   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            any_hit   = any_hit | cell_match[i];
            hit_value = hit_value | (cell_match[i] ? cell_value[i] : '0);
            hit_age   = hit_age | (cell_match[i] ? cell_age[i] : '0);
        end
    end

    // victim and free slot come out of the last cell of the row
    assign evict   = occ_full && ch_valid[ENTRIES];
    assign slot_en = evict || ch_free[ENTRIES];
    always_comb begin
        if (evict) begin
            slot_idx = (ch_free[ENTRIES] && (ch_fidx[ENTRIES] < ch_idx[ENTRIES])) ?
                       ch_fidx[ENTRIES] : ch_idx[ENTRIES];
        end else begin
            slot_idx = ch_fidx[ENTRIES];
        end
    end

    // ---------------- control ----------------
    assign can_load = !r_m_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!cap_zero && !any_hit && (r_action == ACTION_PUT)) begin
                    n_state = ST_SWEEP;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SWEEP: begin
                if (r_sweep == IW'(ENTRIES - 1)) begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (can_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready        = (r_state == ST_IDLE);
        cell_ctl.op          = CELL_HOLD;
        cell_ctl.write_value = (r_action == ACTION_PUT);
        cell_ctl.evict       = 1'b0;
        ref_age              = '0;
        n_occ                = r_occ;
        n_sweep              = '0;
        n_res_hit            = r_res_hit;
        n_res_rd             = r_res_rd;
        n_res_ev             = r_res_ev;
        n_res_evk            = r_res_evk;
        case (r_state)
            ST_LOOKUP: begin
                cell_ctl.op = CELL_MATCH;
            end
            ST_DECIDE: begin
                n_res_hit = 1'b0;
                n_res_rd  = (r_action == ACTION_PUT) ? '0 : '1;
                n_res_ev  = 1'b0;
                n_res_evk = '0;
                if (!cap_zero && any_hit) begin
                    cell_ctl.op = CELL_TOUCH;
                    ref_age     = hit_age;
                    n_res_hit   = 1'b1;
                    n_res_rd    = (r_action == ACTION_PUT) ? '0 : hit_value;
                end
            end
            ST_SWEEP: begin
                n_sweep = r_sweep + 1'b1;
            end
            ST_INSERT: begin
                cell_ctl.evict = evict;
                ref_age        = ch_age[ENTRIES];
                n_res_ev       = evict;
                n_res_evk      = evict ? ch_key[ENTRIES] : '0;
                if (slot_en) begin
                    cell_ctl.op = CELL_INSERT;
                    if (!evict) begin
                        n_occ = r_occ + 1'b1;
                    end
                end
            end
            default: begin
                n_sweep = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_occ     <= '0;
            r_sweep   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_sweep <= n_sweep;
            if ((r_state == ST_DONE) && can_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_action <= s_axis_tuser[0];
            r_key    <= s_axis_tdata[DATA_WIDTH-1:0];
            r_value  <= s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
        end
        r_res_hit <= n_res_hit;
        r_res_rd  <= n_res_rd;
        r_res_ev  <= n_res_ev;
        r_res_evk <= n_res_evk;
        if ((r_state == ST_DONE) && can_load) begin
            r_m_hit <= r_res_hit;
            r_m_rd  <= r_res_rd;
            r_m_ev  <= r_res_ev;
            r_m_evk <= r_res_evk;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_evk, r_m_rd};
    assign m_axis_tuser  = {r_m_ev, r_m_hit};

endmodule
